### rtl/s3tc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3tc_pkg
// Shared types and constants of the s3tc block decoder: format codes,
// register indexes and the block descriptor passed from front to back.
// ----------------------------------------------------------------------------
package s3tc_pkg;

   localparam int unsigned WordW     = 64;
   localparam int unsigned CsrIndexW = 2;
   localparam int unsigned CsrDataW  = 16;
   localparam int unsigned BlockPosW = 14;
   localparam int unsigned PixelPosW = 16;

   // descriptor queue between front and back
   localparam int unsigned DescDepth  = 2;
   localparam int unsigned DescPtrW   = $clog2(DescDepth);
   localparam int unsigned DescCountW = $clog2(DescDepth + 1);

   typedef enum logic [1:0] {
      MODE_DXT1  = 2'd0,
      MODE_DXT1A = 2'd1,
      MODE_DXT3  = 2'd2,
      MODE_DXT5  = 2'd3
   } format_mode_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_FORMAT_MODE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WordW-1:0]     colour_word;
      logic [WordW-1:0]     alpha_word;
      format_mode_type      mode;
      logic [BlockPosW-1:0] column;
      logic [BlockPosW-1:0] row;
      logic                 last_img;
   } block_desc_type;

endpackage

### rtl/s3tc_block_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3tc_block_decoder_core
// S3TC (dxt1, dxt1 one-bit alpha, dxt3, dxt5) block decoder: block words in,
// decoded pixels with image coordinates out.
// ----------------------------------------------------------------------------
//  channel  | ports                           | beat
//  ---------+---------------------------------+---------------------------------
//  request  | req_push, req_full, req_*       | one 64-bit block word
//  response | rsp_empty, rsp_pop, rsp_*       | one decoded pixel
//  csr      | csr_write_enable, csr_index, .. | one register write, no wait
//
//  A colour word yields sixteen pixel beats, one per cycle while rsp_pop is
//  held, set by the pixel walk in the back end; an alpha word yields none.
//  Pixels pass the descriptor queue, first stage and response register.
//  Reset is synchronous and needs no clearing pass.
//  The front keeps taking words while the back stalls until the two-entry
//  descriptor queue fills; a stalled result holds in the response register.
// ----------------------------------------------------------------------------
module s3tc_block_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [s3tc_pkg::WordW-1:0]        req_block_word,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [4:0]                        rsp_red,
   output logic [5:0]                        rsp_green,
   output logic [4:0]                        rsp_blue,
   output logic [7:0]                        rsp_alpha,
   output logic [s3tc_pkg::PixelPosW-1:0]    rsp_pixel_x,
   output logic [s3tc_pkg::PixelPosW-1:0]    rsp_pixel_y,
   output logic                              rsp_last_of_block,
   output logic                              rsp_last_of_image,
   input  logic                              csr_write_enable,
   input  logic [s3tc_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [s3tc_pkg::CsrDataW-1:0]     csr_write_data
);
   import s3tc_pkg::*;

   logic           desc_push, desc_full, desc_pop, desc_empty;
   block_desc_type desc_in, desc_out;

   s3tc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_block_word   (req_block_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .desc_push        (desc_push),
      .desc_data        (desc_in),
      .desc_full        (desc_full)
   );

   s3tc_desc_fifo u_desc_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc_in),
      .full      (desc_full),
      .pop       (desc_pop),
      .pop_data  (desc_out),
      .empty     (desc_empty)
   );

   s3tc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .desc_data         (desc_out),
      .desc_empty        (desc_empty),
      .desc_pop          (desc_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_last_of_block (rsp_last_of_block),
      .rsp_last_of_image (rsp_last_of_image)
   );

endmodule

### rtl/s3tc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3tc_front
// Takes block words, keeps the alpha word of dxt3/dxt5 blocks, tracks the
// block position over the image and hands one descriptor per colour word on.
// ----------------------------------------------------------------------------
module s3tc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [s3tc_pkg::WordW-1:0]        req_block_word,
   input  logic                              csr_write_enable,
   input  logic [s3tc_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [s3tc_pkg::CsrDataW-1:0]     csr_write_data,
   output logic                              desc_push,
   output s3tc_pkg::block_desc_type          desc_data,
   input  logic                              desc_full
);
   import s3tc_pkg::*;

   format_mode_type      mode_ff, mode_in;
   logic [CsrDataW-1:0]  width_ff, width_in;
   logic [CsrDataW-1:0]  height_ff, height_in;
   logic                 pending_ff, pending_in;
   logic [WordW-1:0]     alpha_word_ff;
   logic [BlockPosW-1:0] column_ff, column_in;
   logic [BlockPosW-1:0] row_ff, row_in;

   logic                 accept;
   logic                 alpha_beat;
   logic [BlockPosW-1:0] blocks_w, blocks_h;
   logic                 col_last, row_last, last_img;

   assign req_full   = desc_full;
   assign accept     = req_push && !desc_full;
   assign alpha_beat = (mode_ff == MODE_DXT3 || mode_ff == MODE_DXT5) && !pending_ff;
   assign desc_push  = accept && !alpha_beat;

   // sizes below four pixels still count as one block
   assign blocks_w = (width_ff[CsrDataW-1:2] == '0) ? BlockPosW'(1) : width_ff[CsrDataW-1:2];
   assign blocks_h = (height_ff[CsrDataW-1:2] == '0) ? BlockPosW'(1) : height_ff[CsrDataW-1:2];

   assign col_last = ({1'b0, column_ff} + (BlockPosW+1)'(1)) >= {1'b0, blocks_w};
   assign row_last = ({1'b0, row_ff} + (BlockPosW+1)'(1)) >= {1'b0, blocks_h};
   assign last_img = col_last && row_last;

   assign desc_data = '{colour_word: req_block_word,
                        alpha_word:  alpha_word_ff,
                        mode:        mode_ff,
                        column:      column_ff,
                        row:         row_ff,
                        last_img:    last_img};

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FORMAT_MODE:  mode_in   = format_mode_type'(csr_write_data[1:0]);
            CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      pending_in = pending_ff;
      column_in  = column_ff;
      row_in     = row_ff;
      if (accept) begin
         pending_in = alpha_beat;
      end
      if (desc_push) begin
         if (last_img) begin
            column_in = '0;
            row_in    = '0;
         end else if (col_last) begin
            column_in = '0;
            row_in    = row_ff + BlockPosW'(1);
         end else begin
            column_in = column_ff + BlockPosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_DXT1;
         width_ff   <= CsrDataW'(4);
         height_ff  <= CsrDataW'(4);
         pending_ff <= 1'b0;
         column_ff  <= '0;
         row_ff     <= '0;
      end else begin
         mode_ff    <= mode_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         pending_ff <= pending_in;
         column_ff  <= column_in;
         row_ff     <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && alpha_beat) begin
         alpha_word_ff <= req_block_word;
      end
   end

`ifndef SYNTHESIS
   // an alpha word always leaves the block waiting for its colour word
   a_alpha_sets_pending: assert property (@(posedge clock) disable iff (reset)
      accept && alpha_beat |=> pending_ff)
      else $error("alpha word did not set pending");
`endif

endmodule

### rtl/s3tc_desc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3tc_desc_fifo
// Short queue of block descriptors between the front and the pixel back end.
// ----------------------------------------------------------------------------
module s3tc_desc_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  s3tc_pkg::block_desc_type push_data,
   output logic                     full,
   input  logic                     pop,
   output s3tc_pkg::block_desc_type pop_data,
   output logic                     empty
);
   import s3tc_pkg::*;

   block_desc_type        entry_ff [DescDepth];
   logic [DescPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [DescPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [DescCountW-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = count_ff == DescCountW'(DescDepth);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == DescPtrW'(DescDepth - 1)) ? '0 : wr_ptr_ff + DescPtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == DescPtrW'(DescDepth - 1)) ? '0 : rd_ptr_ff + DescPtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + DescCountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - DescCountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DescCountW'(DescDepth))
      else $error("descriptor queue overfilled");
`endif

endmodule

### rtl/s3tc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3tc_back
// Pixel back end: walks the sixteen texels of a block, one per unstalled
// cycle. The first stage picks palette entries and builds numerators, the
// second divides by reciprocal multiplication into the result register.
// ----------------------------------------------------------------------------
module s3tc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  s3tc_pkg::block_desc_type          desc_data,
   input  logic                              desc_empty,
   output logic                              desc_pop,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [4:0]                        rsp_red,
   output logic [5:0]                        rsp_green,
   output logic [4:0]                        rsp_blue,
   output logic [7:0]                        rsp_alpha,
   output logic [s3tc_pkg::PixelPosW-1:0]    rsp_pixel_x,
   output logic [s3tc_pkg::PixelPosW-1:0]    rsp_pixel_y,
   output logic                              rsp_last_of_block,
   output logic                              rsp_last_of_image
);
   import s3tc_pkg::*;

   typedef enum logic [1:0] {
      COL_RAW   = 2'd0,
      COL_HALF  = 2'd1,
      COL_THIRD = 2'd2
   } colour_op_type;

   typedef enum logic [1:0] {
      ALP_RAW     = 2'd0,
      ALP_SEVENTH = 2'd1,
      ALP_FIFTH   = 2'd2
   } alpha_op_type;

   typedef struct packed {
      logic [7:0]  num;
      colour_op_type op;
   } chan_type;

   typedef struct packed {
      logic [7:0]           red_num;
      logic [7:0]           green_num;
      logic [7:0]           blue_num;
      colour_op_type        colour_op;
      logic [10:0]          alpha_num;
      alpha_op_type         alpha_op;
      logic [PixelPosW-1:0] x;
      logic [PixelPosW-1:0] y;
      logic                 last_block;
      logic                 last_img;
   } pixel_stage_type;

   // palette entry of one channel as numerator plus divide to apply
   function automatic chan_type chan_sel(input logic [5:0] a, input logic [5:0] b,
                                         input logic [1:0] idx, input logic three);
      chan_type res;
      res.num = {2'b00, a};
      res.op  = COL_RAW;
      case (idx)
         2'd0: begin
            res.num = {2'b00, a};
         end
         2'd1: begin
            res.num = {2'b00, b};
         end
         2'd2: begin
            if (three) begin
               res.num = {2'b00, a} + {2'b00, b} + 8'd1;
               res.op  = COL_HALF;
            end else begin
               res.num = {1'b0, a, 1'b0} + {2'b00, b} + 8'd2;
               res.op  = COL_THIRD;
            end
         end
         2'd3: begin
            if (three) begin
               res.num = '0;
            end else begin
               res.num = {2'b00, a} + {1'b0, b, 1'b0} + 8'd2;
               res.op  = COL_THIRD;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // n/3 as (n * 171) >> 9, exact for n below 512
   function automatic logic [5:0] colour_div(input logic [7:0] num, input colour_op_type op);
      logic [15:0] prod;
      logic [5:0]  res;
      prod = {8'd0, num} * 16'd171;
      case (op)
         COL_RAW:   res = num[5:0];
         COL_HALF:  res = num[6:1];
         COL_THIRD: res = prod[14:9];
         default:   res = num[5:0];
      endcase
      return res;
   endfunction

   logic [3:0]      pix_ff, pix_in;
   logic            s1_valid_ff, s1_valid_in;
   pixel_stage_type s1_ff, s1_in;
   logic            s2_valid_ff, s2_valid_in;

   logic            s2_ready, s1_adv, issue;

   logic [15:0]     c0, c1;
   logic            three_col;
   logic [31:0]     idx_bits;
   logic [1:0]      idx;
   chan_type        red_sel, green_sel, blue_sel;
   logic [7:0]      a0, a1;
   logic [47:0]     k_bits;
   logic [5:0]      k_offset;
   logic [2:0]      k;
   logic [2:0]      wf0, wf1;

   logic [23:0]     alpha_prod;
   logic [5:0]      red_full, green_full, blue_full;
   logic [7:0]      alpha_fin;

   assign s2_ready  = !s2_valid_ff || rsp_pop;
   assign s1_adv    = !s1_valid_ff || s2_ready;
   assign issue     = s1_adv && !desc_empty;
   assign desc_pop  = issue && (pix_ff == 4'hF);
   assign rsp_empty = !s2_valid_ff;

   assign c0        = desc_data.colour_word[15:0];
   assign c1        = desc_data.colour_word[31:16];
   assign three_col = (desc_data.mode == MODE_DXT1A) && (c0 <= c1);
   assign idx_bits  = desc_data.colour_word[63:32];
   assign idx       = idx_bits[{pix_ff, 1'b0} +: 2];

   assign red_sel   = chan_sel({1'b0, c0[15:11]}, {1'b0, c1[15:11]}, idx, three_col);
   assign green_sel = chan_sel(c0[10:5], c1[10:5], idx, three_col);
   assign blue_sel  = chan_sel({1'b0, c0[4:0]}, {1'b0, c1[4:0]}, idx, three_col);

   assign a0       = desc_data.alpha_word[7:0];
   assign a1       = desc_data.alpha_word[15:8];
   assign k_bits   = desc_data.alpha_word[63:16];
   assign k_offset = {1'b0, pix_ff, 1'b0} + {2'b00, pix_ff};
   assign k        = k_bits[k_offset +: 3];

   always_comb begin
      wf0 = 3'(4'd8 - {1'b0, k});
      wf1 = k - 3'd1;
      if (a0 <= a1) begin
         wf0 = 3'(4'd6 - {1'b0, k});
      end
   end

   always_comb begin
      s1_in.red_num    = red_sel.num;
      s1_in.green_num  = green_sel.num;
      s1_in.blue_num   = blue_sel.num;
      s1_in.colour_op  = red_sel.op;
      s1_in.alpha_num  = 11'd1;
      s1_in.alpha_op   = ALP_RAW;
      s1_in.x          = {desc_data.column, pix_ff[1:0]};
      s1_in.y          = {desc_data.row, pix_ff[3:2]};
      s1_in.last_block = pix_ff == 4'hF;
      s1_in.last_img   = desc_data.last_img && (pix_ff == 4'hF);
      case (desc_data.mode)
         MODE_DXT3: begin
            s1_in.alpha_num = {7'd0, desc_data.alpha_word[{pix_ff, 2'b00} +: 4]};
         end
         MODE_DXT5: begin
            if (k == 3'd0) begin
               s1_in.alpha_num = {3'd0, a0};
            end else if (k == 3'd1) begin
               s1_in.alpha_num = {3'd0, a1};
            end else if (a0 > a1) begin
               s1_in.alpha_num = {8'd0, wf0} * {3'd0, a0} + {8'd0, wf1} * {3'd0, a1} + 11'd3;
               s1_in.alpha_op  = ALP_SEVENTH;
            end else if (k == 3'd6) begin
               s1_in.alpha_num = 11'd0;
            end else if (k == 3'd7) begin
               s1_in.alpha_num = 11'd255;
            end else begin
               s1_in.alpha_num = {8'd0, wf0} * {3'd0, a0} + {8'd0, wf1} * {3'd0, a1} + 11'd2;
               s1_in.alpha_op  = ALP_FIFTH;
            end
         end
         default: begin
            // one-bit alpha drops out only on the black entry of three-colour mode
            s1_in.alpha_num = (three_col && idx == 2'd3) ? 11'd0 : 11'd1;
         end
      endcase
   end

   always_comb begin
      pix_in      = pix_ff;
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      if (issue) begin
         pix_in = pix_ff + 4'd1;
      end
      if (s1_adv) begin
         s1_valid_in = !desc_empty;
      end
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         pix_ff      <= pix_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // one shared multiplier: 4682 / 2^15 for sevenths, 6554 / 2^15 for fifths
   assign alpha_prod = {13'd0, s1_ff.alpha_num}
                     * ((s1_ff.alpha_op == ALP_SEVENTH) ? 24'd4682 : 24'd6554);
   assign alpha_fin  = (s1_ff.alpha_op == ALP_RAW) ? s1_ff.alpha_num[7:0] : alpha_prod[22:15];
   assign red_full   = colour_div(s1_ff.red_num, s1_ff.colour_op);
   assign green_full = colour_div(s1_ff.green_num, s1_ff.colour_op);
   assign blue_full  = colour_div(s1_ff.blue_num, s1_ff.colour_op);

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         rsp_red           <= red_full[4:0];
         rsp_green         <= green_full;
         rsp_blue          <= blue_full[4:0];
         rsp_alpha         <= alpha_fin;
         rsp_pixel_x       <= s1_ff.x;
         rsp_pixel_y       <= s1_ff.y;
         rsp_last_of_block <= s1_ff.last_block;
         rsp_last_of_image <= s1_ff.last_img;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_on_empty: assert property (@(posedge clock) disable iff (reset)
      desc_pop |-> !desc_empty)
      else $error("descriptor popped from empty queue");

   a_image_end_is_block_end: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_of_image |-> rsp_last_of_block)
      else $error("end of image not on end of block");

   a_block_end_corner: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_of_block |-> rsp_pixel_x[1:0] == 2'd3 && rsp_pixel_y[1:0] == 2'd3)
      else $error("end of block not on bottom right texel");
`endif

endmodule

### dv/s3tc_block_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3tc_block_decoder_core_tb
// Drives block words into the decoder and checks every decoded pixel. The
// expected pixels are worked out by a behavioural decoder in this bench,
// in order, as each word is taken. A short directed part covers the palette
// modes, the alpha modes, size and mode changes part way through. Random
// phases with random register settings follow. Both sides stall at random.
// ----------------------------------------------------------------------------
module s3tc_block_decoder_core_tb;
   import s3tc_pkg::*;

   localparam int unsigned StallLimit = 1000;
   localparam int unsigned WordTarget = 280;

   typedef struct packed {
      logic [4:0]  red;
      logic [5:0]  green;
      logic [4:0]  blue;
      logic [7:0]  alpha;
      logic [15:0] x;
      logic [15:0] y;
      logic        last_blk;
      logic        last_img;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [WordW-1:0]     req_block_word = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [4:0]           rsp_red;
   logic [5:0]           rsp_green;
   logic [4:0]           rsp_blue;
   logic [7:0]           rsp_alpha;
   logic [PixelPosW-1:0] rsp_pixel_x;
   logic [PixelPosW-1:0] rsp_pixel_y;
   logic                 rsp_last_of_block;
   logic                 rsp_last_of_image;
   logic                 csr_write_enable = 1'b0;
   logic [CsrIndexW-1:0] csr_index = CSR_FORMAT_MODE;
   logic [CsrDataW-1:0]  csr_write_data = '0;

   // decoder state as seen by the bench
   format_mode_type      cfg_mode = MODE_DXT1;
   logic [15:0]          cfg_width = 16'd4;
   logic [15:0]          cfg_height = 16'd4;
   bit                   alpha_held = 1'b0;
   logic [63:0]          alpha_saved = '0;
   logic [BlockPosW-1:0] blk_col = '0;
   logic [BlockPosW-1:0] blk_row = '0;

   logic [63:0]          pending_words[$];
   pixel_type            expected_pixels[$];
   bit                   send_quiet = 1'b0;
   bit                   take_quiet = 1'b0;
   int unsigned          send_wait = 0;
   int unsigned          take_wait = 0;
   int unsigned          idle_cycles = 0;
   int unsigned          mismatches = 0;

   s3tc_block_decoder_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_block_word    (req_block_word),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_last_of_block (rsp_last_of_block),
      .rsp_last_of_image (rsp_last_of_image),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned grid_span(logic [15:0] pixels);
      return ((pixels < 16'd4) ? 32'd4 : 32'(pixels)) >> 2;
   endfunction

   // one word taken: store an alpha word or expand a colour word to 16 pixels
   task automatic decode_block(input logic [63:0] word);
      int unsigned red_pal[4], grn_pal[4], blu_pal[4], one_bit[4], alf_pal[8];
      logic [63:0] aword;
      logic [15:0] c0, c1;
      int unsigned across, down, idx, k, i;
      bit last_img;
      pixel_type px;
      aword = '0;
      if (cfg_mode == MODE_DXT3 || cfg_mode == MODE_DXT5) begin
         if (!alpha_held) begin
            alpha_saved = word;
            alpha_held = 1'b1;
            return;
         end
         aword = alpha_saved;
      end
      alpha_held = 1'b0;

      c0 = word[15:0];
      c1 = word[31:16];
      red_pal[0] = c0[15:11]; grn_pal[0] = c0[10:5]; blu_pal[0] = c0[4:0];
      red_pal[1] = c1[15:11]; grn_pal[1] = c1[10:5]; blu_pal[1] = c1[4:0];
      for (k = 0; k < 4; k++) one_bit[k] = 1;
      if (cfg_mode == MODE_DXT1A && c0 <= c1) begin
         // three-colour block: midpoint and transparent black
         red_pal[2] = (red_pal[0] + red_pal[1] + 1) / 2;
         grn_pal[2] = (grn_pal[0] + grn_pal[1] + 1) / 2;
         blu_pal[2] = (blu_pal[0] + blu_pal[1] + 1) / 2;
         red_pal[3] = 0; grn_pal[3] = 0; blu_pal[3] = 0; one_bit[3] = 0;
      end else begin
         red_pal[2] = (2 * red_pal[0] + red_pal[1] + 2) / 3;
         grn_pal[2] = (2 * grn_pal[0] + grn_pal[1] + 2) / 3;
         blu_pal[2] = (2 * blu_pal[0] + blu_pal[1] + 2) / 3;
         red_pal[3] = (red_pal[0] + 2 * red_pal[1] + 2) / 3;
         grn_pal[3] = (grn_pal[0] + 2 * grn_pal[1] + 2) / 3;
         blu_pal[3] = (blu_pal[0] + 2 * blu_pal[1] + 2) / 3;
      end

      alf_pal[0] = aword[7:0];
      alf_pal[1] = aword[15:8];
      if (alf_pal[0] > alf_pal[1]) begin
         for (k = 2; k < 8; k++)
            alf_pal[k] = ((8 - k) * alf_pal[0] + (k - 1) * alf_pal[1] + 3) / 7;
      end else begin
         for (k = 2; k < 6; k++)
            alf_pal[k] = ((6 - k) * alf_pal[0] + (k - 1) * alf_pal[1] + 2) / 5;
         alf_pal[6] = 0;
         alf_pal[7] = 255;
      end

      across = grid_span(cfg_width);
      down = grid_span(cfg_height);
      last_img = (blk_col + 1 >= across) && (blk_row + 1 >= down);

      for (i = 0; i < 16; i++) begin
         idx = word[32 + 2 * i +: 2];
         px.red = 5'(red_pal[idx]);
         px.green = 6'(grn_pal[idx]);
         px.blue = 5'(blu_pal[idx]);
         case (cfg_mode)
            MODE_DXT3: px.alpha = {4'd0, aword[4 * i +: 4]};
            MODE_DXT5: px.alpha = 8'(alf_pal[aword[16 + 3 * i +: 3]]);
            default:   px.alpha = 8'(one_bit[idx]);
         endcase
         px.x = 16'(blk_col * 4 + i % 4);
         px.y = 16'(blk_row * 4 + i / 4);
         px.last_blk = (i == 15);
         px.last_img = (i == 15) && last_img;
         expected_pixels.push_back(px);
      end

      if (last_img) begin
         blk_col = '0;
         blk_row = '0;
      end else if (blk_col + 1 >= across) begin
         blk_col = '0;
         blk_row = blk_row + 1'b1;
      end else begin
         blk_col = blk_col + 1'b1;
      end
   endtask

   function automatic void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] word;
      word = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: word[31:0] = '0;
         1: word[31:0] = '1;
         2: word[31:16] = word[15:0];
         3: word[15:8] = word[7:0];
         4: word = '1;
         default: ;
      endcase
      return word;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_push && !req_full)
            decode_block(req_block_word);
         if (!req_push || !req_full) begin
            if (send_wait != 0) begin
               req_push <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (pending_words.size() != 0) begin
               req_push <= 1'b1;
               req_block_word <= pending_words.pop_front();
               send_wait <= send_quiet ? 0 : $urandom_range(0, 15);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : pixel_monitor
      pixel_type want;
      int unsigned gap;
      if (reset) begin
         rsp_pop <= 1'b0;
         take_wait <= 0;
      end else if (rsp_pop && !rsp_empty) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: pixel x %0d y %0d arrived with none expected", $time,
                     rsp_pixel_x, rsp_pixel_y);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            compare_field("red", want.red, rsp_red);
            compare_field("green", want.green, rsp_green);
            compare_field("blue", want.blue, rsp_blue);
            compare_field("alpha", want.alpha, rsp_alpha);
            compare_field("pixel_x", want.x, rsp_pixel_x);
            compare_field("pixel_y", want.y, rsp_pixel_y);
            compare_field("last_of_block", want.last_blk, rsp_last_of_block);
            compare_field("last_of_image", want.last_img, rsp_last_of_image);
         end
         gap = take_quiet ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            take_wait <= gap - 1;
         end
      end else if (!rsp_pop) begin
         if (take_wait == 0)
            rsp_pop <= 1'b1;
         else
            take_wait <= take_wait - 1;
      end
   end

   // watchdog: no beat and no register write for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic program_format(input format_mode_type mode, input logic [15:0] width,
                                 input logic [15:0] height);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_FORMAT_MODE;
      csr_write_data <= CsrDataW'(mode);
      @(posedge clock);
      csr_index <= CSR_IMAGE_WIDTH;
      csr_write_data <= width;
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_write_data <= height;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_mode = mode;
      cfg_width = width;
      cfg_height = height;
      @(negedge clock);
   endtask

   // stimulus holds off until every word is in and every pixel is out
   task automatic settle();
      @(negedge clock);
      while (pending_words.size() != 0 || req_push || expected_pixels.size() != 0)
         @(negedge clock);
      // a stored alpha word gives no pixel, so leave it time to land
      repeat (8) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned words_sent, phase, count;
      format_mode_type mode;
      logic [15:0] width, height;
      words_sent = 0;
      phase = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: four-colour, single 4x4 block image
      pending_words.push_back(64'h0);
      pending_words.push_back('1);
      pending_words.push_back(64'hE4E4_E4E4_0000_FFFF);
      settle();

      // one-bit alpha: c0 < c1, c0 == c1, then c0 < c1 again
      program_format(MODE_DXT1A, 16'd8, 16'd4);
      pending_words.push_back(64'hE4E4_E4E4_F81F_07E0);
      pending_words.push_back(64'h1BE4_E41B_1234_1234);
      pending_words.push_back(64'hE4E4_E4E4_FFFF_0001);
      settle();

      // 4-bit alpha, alpha word then colour word
      program_format(MODE_DXT3, 16'd4, 16'd8);
      pending_words.push_back(64'h0123_4567_89AB_CDEF);
      pending_words.push_back(64'hE4E4_E4E4_7BEF_8410);
      pending_words.push_back('1);
      pending_words.push_back(64'h3C5A_96E1_07FF_F800);
      settle();

      // interpolated alpha: a0 > a1, a0 < a1, a0 == a1; indices 0..7 twice
      program_format(MODE_DXT5, 16'd12, 16'd12);
      pending_words.push_back(64'hFAC6_88FA_C688_20F0);
      pending_words.push_back(64'hE4E4_E4E4_001F_FFE0);
      pending_words.push_back(64'hFAC6_88FA_C688_FF00);
      pending_words.push_back(64'h1B1B_1B1B_FFFF_0000);
      pending_words.push_back(64'hFAC6_88FA_C688_8080);
      pending_words.push_back(64'hE4E4_E4E4_5555_AAAA);
      settle();

      // shrink the grid part way through an image
      program_format(MODE_DXT1, 16'd12, 16'd12);
      pending_words.push_back(64'hE4E4_E4E4_1234_5678);
      settle();
      program_format(MODE_DXT1, 16'd4, 16'd8);
      pending_words.push_back(64'h4E4E_4E4E_8765_4321);
      settle();

      // mode change with an alpha word held
      program_format(MODE_DXT3, 16'd4, 16'd4);
      pending_words.push_back(64'hFEDC_BA98_7654_3210);
      settle();
      program_format(MODE_DXT1, 16'd4, 16'd4);
      pending_words.push_back(64'hE4E4_E4E4_F800_001F);
      settle();
      program_format(MODE_DXT5, 16'd4, 16'd4);
      pending_words.push_back(64'h0F1E_2D3C_4B5A_6978);
      settle();
      program_format(MODE_DXT3, 16'd4, 16'd4);
      pending_words.push_back(64'hB4B4_B4B4_07E0_F81F);
      settle();

      while (words_sent < WordTarget) begin
         mode = format_mode_type'($urandom_range(0, 3));
         case ($urandom_range(0, 7))
            0: width = 16'hFFFF;
            1: width = 16'($urandom_range(1, 3));
            2: width = 16'($urandom_range(4, 65535));
            default: width = 16'($urandom_range(4, 24));
         endcase
         case ($urandom_range(0, 7))
            0: height = 16'hFFFF;
            1: height = 16'($urandom_range(1, 3));
            2: height = 16'($urandom_range(4, 65535));
            default: height = 16'($urandom_range(4, 24));
         endcase
         if (phase == 0) begin
            mode = MODE_DXT5;
            width = 16'hFFFF;
            height = 16'hFFFF;
         end else if (phase == 1) begin
            mode = MODE_DXT1A;
            width = 16'd1;
            height = 16'd1;
         end
         send_quiet = ($urandom_range(0, 3) == 0);
         take_quiet = ($urandom_range(0, 3) == 0);
         program_format(mode, width, height);
         count = $urandom_range(8, 30);
         repeat (count) pending_words.push_back(random_word());
         words_sent += count;
         phase++;
         settle();
      end

      repeat (40) @(negedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### files.f
rtl/s3tc_pkg.sv
rtl/s3tc_front.sv
rtl/s3tc_desc_fifo.sv
rtl/s3tc_back.sv
rtl/s3tc_block_decoder_core.sv
dv/s3tc_block_decoder_core_tb.sv
